// ===== rtl/core/sva_pkg.sv =====
// Shared types and constants of the sampler voice allocator.
// Used by sva_note_map, sva_voice_engine and sampler_voice_allocator_top.
package sva_pkg;

  localparam logic [6:0] NOTE_BASE    = 7'd36;
  localparam logic [6:0] NOTE_PREVIEW = 7'd37;
  localparam logic [6:0] NOTE_SEQ     = 7'd39;
  localparam logic [2:0] KEYS_PER_OCT = 3'd7;

  // reciprocal of 12 as 171 / 2048, exact for offsets up to 91
  localparam logic [7:0] RECIP_12     = 8'd171;
  localparam logic [3:0] NOTES_PER_OCT = 4'd12;

  // white-key flag and slot within the octave, C first
  localparam logic [11:0] KEY_WHITE = 12'b1010_1011_0101;
  localparam logic [2:0] KEY_SLOT [12] = '{3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd3,
                                           3'd0, 3'd4, 3'd0, 3'd5, 3'd0, 3'd6};

  typedef enum logic [1:0] {
    CFG_SAMPLE_PRESENT = 2'd0,
    CFG_SLICE_COUNT    = 2'd1,
    CFG_ONE_SHOT_MASK  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_FINISHED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_SLICE     = 3'd1,
    ST_PREVIEW   = 3'd2,
    ST_SEQ_START = 3'd3,
    ST_SEQ_STOP  = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_ALL_OFF   = 3'd6,
    ST_FINISHED  = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REQ_IGNORE  = 3'd0,
    REQ_START   = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_ALL_OFF = 3'd3,
    REQ_FINISH  = 3'd4,
    REQ_SEQ_ON  = 3'd5,
    REQ_SEQ_OFF = 3'd6
  } req_kind_e;

  // decoded event handed to the voice engine
  typedef struct packed {
    req_kind_e   kind;
    logic        preview;   // start is a full-sample preview
    logic        clear;     // one-shot slice: silence same-slice voices first
    logic [6:0]  note;
    logic [5:0]  slice;
    logic [6:0]  vel;
    logic [3:0]  fin;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  voice;
    logic [5:0]  slice;
    logic [6:0]  vel;
    logic        stolen;
    logic [15:0] released;
    logic [15:0] active;
    logic        seq;
  } res_t;

endpackage

// ===== rtl/core/sva_note_map.sv =====
// Maps a MIDI note to a slice index: white keys from note 36 upward.
// Depends on sva_pkg (constants, key table).
module sva_note_map (
  input  logic [6:0] note_i,
  output logic       valid_o,
  output logic [5:0] slice_o
);
  import sva_pkg::*;

  logic [6:0]  off;
  logic [14:0] prod;
  logic [2:0]  oct;
  logic [6:0]  oct_x12;
  logic [3:0]  rem;
  logic [5:0]  oct_x7;

  always_comb begin
    off     = note_i - NOTE_BASE;
    prod    = 15'(off) * 15'(RECIP_12);
    oct     = prod[13:11];
    oct_x12 = 7'(oct) * 7'(NOTES_PER_OCT);
    rem     = 4'(off - oct_x12);
    oct_x7  = 6'(oct) * 6'(KEYS_PER_OCT);
    valid_o = (note_i >= NOTE_BASE) && (rem < NOTES_PER_OCT) && KEY_WHITE[rem];
    slice_o = oct_x7 + 6'(KEY_SLOT[rem]);
  end

endmodule

// ===== rtl/core/sva_voice_engine.sv =====
// Voice table and scan sequencer: one shared compare unit walks the voices
// one per cycle for one-shot silencing, free-voice search and note-off.
// Depends on sva_pkg (req_t, res_t, status codes).
module sva_voice_engine #(
  parameter int NUM_VOICES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sva_pkg::req_t    req_i,
  input  logic [63:0]      oneshot_mask_i,
  output logic             ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sva_pkg::res_t    res_o
);
  import sva_pkg::*;

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [VW-1:0] LAST = VW'(NUM_VOICES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL, S_DONE} state_e;

  state_e                 state_q, state_d;
  logic [NUM_VOICES-1:0]  active_q, active_d;
  logic [NUM_VOICES-1:0]  before_q, before_d;
  logic [VW-1:0]          idx_q, idx_d;
  logic [VW-1:0]          free_q, free_d;
  logic                   found_q, found_d;
  logic [VW-1:0]          sp_q, sp_d;
  logic                   seq_q, seq_d;
  req_t                   req_q, req_d;
  res_t                   res_q, res_d;

  // note and slice per voice, read only for active voices
  logic [6:0]             note_mem [NUM_VOICES];
  logic [5:0]             slice_mem [NUM_VOICES];

  logic [6:0]             cur_note_q;
  logic [5:0]             cur_slice_q;
  logic                   cur_act;
  logic [6:0]             key_a, key_b;
  logic                   key_eq, hit;
  logic [VW-1:0]          alloc_v;
  logic                   wr_en;

  assign cur_act = active_q[idx_q];

  // shared compare: slice match on a start, note match on a release
  always_comb begin
    if (req_q.kind == REQ_START) begin
      key_a = {1'b0, cur_slice_q};
      key_b = {1'b0, req_q.slice};
    end else begin
      key_a = cur_note_q;
      key_b = req_q.note;
    end
    key_eq = (key_a == key_b);
    if (req_q.kind == REQ_START) begin
      hit = cur_act && key_eq && req_q.clear;
    end else begin
      hit = cur_act && key_eq && !oneshot_mask_i[cur_slice_q];
    end
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    before_d = before_q;
    idx_d    = idx_q;
    free_d   = free_q;
    found_d  = found_q;
    sp_d     = sp_q;
    seq_d    = seq_q;
    req_d    = req_q;
    res_d    = res_q;
    alloc_v  = found_q ? free_q : sp_q;
    wr_en    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          before_d = active_q;
          idx_d    = '0;
          found_d  = 1'b0;
          if (req_i.kind == REQ_START || req_i.kind == REQ_RELEASE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINAL;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          active_d[idx_q] = 1'b0;
        end
        // lowest free voice, counting ones just silenced
        if (req_q.kind == REQ_START && !found_q && (!cur_act || hit)) begin
          found_d = 1'b1;
          free_d  = idx_q;
        end
        if (idx_q == LAST) begin
          state_d = S_FINAL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FINAL: begin
        res_d        = '0;
        res_d.status = ST_IGNORED;
        case (req_q.kind)
          REQ_START: begin
            res_d.status = req_q.preview ? ST_PREVIEW : ST_SLICE;
            res_d.voice  = 4'(alloc_v);
            res_d.slice  = req_q.slice;
            res_d.vel    = req_q.vel;
            res_d.stolen = active_q[alloc_v];
            active_d[alloc_v] = 1'b1;
            wr_en = 1'b1;
            if (!found_q) begin
              sp_d = (sp_q == LAST) ? '0 : sp_q + 1'b1;
            end
          end
          REQ_RELEASE: res_d.status = ST_RELEASED;
          REQ_ALL_OFF: begin
            active_d     = '0;
            res_d.status = ST_ALL_OFF;
          end
          REQ_FINISH: begin
            active_d[req_q.fin[VW-1:0]] = 1'b0;
            res_d.status = ST_FINISHED;
          end
          REQ_SEQ_ON: begin
            seq_d        = 1'b1;
            res_d.status = ST_SEQ_START;
          end
          REQ_SEQ_OFF: begin
            seq_d        = 1'b0;
            res_d.status = ST_SEQ_STOP;
          end
          default: res_d.status = ST_IGNORED;
        endcase
        res_d.released = 16'(before_q & ~active_d);
        res_d.active   = 16'(active_d);
        res_d.seq      = seq_d;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      before_q <= '0;
      idx_q    <= '0;
      free_q   <= '0;
      found_q  <= 1'b0;
      sp_q     <= '0;
      seq_q    <= 1'b0;
      req_q    <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      before_q <= before_d;
      idx_q    <= idx_d;
      free_q   <= free_d;
      found_q  <= found_d;
      sp_q     <= sp_d;
      seq_q    <= seq_d;
      req_q    <= req_d;
      res_q    <= res_d;
    end
  end

  // table write on allocation; read one step ahead of the scan index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      note_mem[alloc_v]  <= req_q.note;
      slice_mem[alloc_v] <= req_q.slice;
    end
    cur_note_q  <= note_mem[idx_d];
    cur_slice_q <= slice_mem[idx_d];
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("start while busy");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= LAST)
    else $error("steal pointer out of range");

  a_scan_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (req_q.kind == REQ_START || req_q.kind == REQ_RELEASE))
    else $error("scan for an event without voice search");

  a_started_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_q.status == ST_SLICE || res_q.status == ST_PREVIEW))
    |-> active_q[res_q.voice[VW-1:0]])
    else $error("started voice not active");

  a_released_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_q.released & res_q.active) == 16'd0)
    else $error("released voice still active");

endmodule

// ===== rtl/core/sampler_voice_allocator_top.sv =====
// Top level of the sampler voice allocator: stream ports, configuration
// registers, event decode and result register. Depends on sva_pkg,
// sva_note_map and sva_voice_engine.

// Voice allocator for a slicing sampler. Each input item is one event (note
// on, note off, all notes off, voice finished) and gives exactly one result
// item. A note-on that starts a voice and a note-off of any note but 39 walk
// the voice table through one shared compare unit, one voice per cycle, so
// such an item passes, while the output is free, through these steps from
// one accepting edge to the next: accept, one scan step per voice, one
// allocate/write-back step and one hand-off to the result register. All
// other events, ignored note-ons and note 39 included, skip the scan steps.
// A stalled output holds the hand-off. The input is not ready while an item
// is in work; the result register lets the next item be taken while a
// finished result still waits on the output. A new voice is the lowest free
// one (a voice just silenced by a one-shot retrigger counts as free),
// otherwise the voice at a round-robin steal pointer. Configuration must be
// written by the user only while idle; the block itself does not enforce it.
// cfg_ready_o is always high. Note and slice per voice have no reset and
// are only read for active voices.
module sampler_voice_allocator_top #(
  parameter int NUM_VOICES = 16,
  parameter int MAX_SLICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // events
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // note[6:0], velocity[13:7], finished_voice[17:14]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // voice_index[3:0], slice_num[9:4], velocity_out[16:10], stolen[17],
  // released_mask[33:18], active_mask[49:34], seq_running[50]
  output logic [55:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import sva_pkg::*;

  logic        sample_present_q;
  logic [6:0]  slice_count_q;
  logic [63:0] oneshot_q;

  logic [6:0]  in_note;
  logic [6:0]  in_vel;
  logic [3:0]  in_fin;
  op_e         in_op;

  logic        map_valid;
  logic [5:0]  map_slice;
  logic [6:0]  slices;
  req_t        req;

  logic        eng_ready;
  logic        start;
  logic        res_valid;
  logic        res_ready;
  res_t        res;

  logic        out_valid_q;
  res_t        out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_present_q <= 1'b0;
      slice_count_q    <= '0;
      oneshot_q        <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SAMPLE_PRESENT: sample_present_q <= cfg_data_i[0];
        CFG_SLICE_COUNT:    slice_count_q    <= cfg_data_i[6:0];
        CFG_ONE_SHOT_MASK:  oneshot_q        <= cfg_data_i;
        default: ;  // unknown index: no register
      endcase
    end
  end

  assign in_note = s_axis_tdata[6:0];
  assign in_vel  = s_axis_tdata[13:7];
  assign in_fin  = s_axis_tdata[17:14];
  assign in_op   = op_e'(s_axis_tuser);

  sva_note_map u_note_map (
    .note_i  (in_note),
    .valid_o (map_valid),
    .slice_o (map_slice)
  );

  // slice counts beyond MAX_SLICES act as MAX_SLICES
  assign slices = (slice_count_q > 7'(MAX_SLICES)) ? 7'(MAX_SLICES) : slice_count_q;

  // event decode
  always_comb begin
    req         = '0;
    req.kind    = REQ_IGNORE;
    req.note    = in_note;
    req.vel     = in_vel;
    req.fin     = in_fin;
    case (in_op)
      OP_NOTE_ON: begin
        if (sample_present_q) begin
          if (in_note == NOTE_SEQ) begin
            if (slices != 7'd0) begin
              req.kind = REQ_SEQ_ON;
            end
          end else if (in_note == NOTE_PREVIEW) begin
            // preview plays the whole sample, even with no slices
            req.kind    = REQ_START;
            req.preview = 1'b1;
          end else if (map_valid && ({1'b0, map_slice} < slices)) begin
            req.kind  = REQ_START;
            req.slice = map_slice;
            req.clear = oneshot_q[map_slice];
          end
        end
      end
      OP_NOTE_OFF: begin
        // applied whether or not a sample is loaded
        req.kind = (in_note == NOTE_SEQ) ? REQ_SEQ_OFF : REQ_RELEASE;
      end
      OP_ALL_OFF: req.kind = REQ_ALL_OFF;
      OP_FINISHED: begin
        if ({1'b0, in_fin} < 5'(NUM_VOICES)) begin
          req.kind = REQ_FINISH;
        end
      end
      default: req.kind = REQ_IGNORE;
    endcase
  end

  assign s_axis_tready = eng_ready;
  assign start         = s_axis_tvalid && eng_ready;

  sva_voice_engine #(
    .NUM_VOICES (NUM_VOICES)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_i          (req),
    .oneshot_mask_i (oneshot_q),
    .ready_o        (eng_ready),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // result register: frees the engine while the sink stalls
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {5'd0, out_q.seq, out_q.active, out_q.released, out_q.stolen,
                          out_q.vel, out_q.slice, out_q.voice};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sampler_voice_allocator_top: voice table predictor,
// stream drivers with random gaps, per-field result compare.
// Depends on sva_pkg and the allocator RTL.

module tb;
  import sva_pkg::*;

  // one predicted result item, fields in tdata order
  typedef struct {
    status_e     status;
    logic [3:0]  voice;
    logic [5:0]  slice;
    logic [6:0]  vel;
    logic        stolen;
    logic [15:0] released;
    logic [15:0] active;
    logic        seq;
  } voice_result_t;

  // Voice table predictor plus the queue of results still owed by the block.
  class voice_scoreboard;
    localparam int VOICES      = 16;
    localparam int SLICE_LIMIT = 64;

    voice_result_t due_results[$];
    int unsigned   errors;

    logic        have_sample;
    logic [6:0]  slice_total;
    logic [63:0] oneshot_bits;

    logic [15:0] voice_on;
    logic [6:0]  voice_key[VOICES];
    logic [5:0]  voice_slice[VOICES];
    logic [3:0]  steal_ptr;
    logic        seq_on;

    function new();
      errors       = 0;
      have_sample  = 1'b0;
      slice_total  = '0;
      oneshot_bits = '0;
      voice_on     = '0;
      steal_ptr    = '0;
      seq_on       = 1'b0;
      foreach (voice_key[i]) begin
        voice_key[i]   = '0;
        voice_slice[i] = '0;
      end
    endfunction

    function void set_register(cfg_idx_e idx, logic [63:0] value);
      case (idx)
        CFG_SAMPLE_PRESENT: have_sample  = value[0];
        CFG_SLICE_COUNT:    slice_total  = value[6:0];
        CFG_ONE_SHOT_MASK:  oneshot_bits = value;
        default: ;
      endcase
    endfunction

    // white keys from the base note count up 7 slices per octave
    function int key_to_slice(logic [6:0] key);
      int offset;
      int slot;
      if (key < NOTE_BASE) return -1;
      offset = int'(key) - int'(NOTE_BASE);
      case (offset % 12)
        0:       slot = 0;
        2:       slot = 1;
        4:       slot = 2;
        5:       slot = 3;
        7:       slot = 4;
        9:       slot = 5;
        11:      slot = 6;
        default: return -1;
      endcase
      return (offset / 12) * int'(KEYS_PER_OCT) + slot;
    endfunction

    // accepted event: update the table, queue the result it must produce
    function void note_event(op_e op, logic [6:0] key, logic [6:0] vel, logic [3:0] fin);
      voice_result_t r;
      logic [15:0]   was_on;
      int            limit;
      int            s;
      int            v;
      bit            go;
      was_on     = voice_on;
      r.status   = ST_IGNORED;
      r.voice    = '0;
      r.slice    = '0;
      r.vel      = '0;
      r.stolen   = 1'b0;
      limit      = (int'(slice_total) > SLICE_LIMIT) ? SLICE_LIMIT : int'(slice_total);
      case (op)
        OP_NOTE_ON: begin
          if (have_sample) begin
            if (key == NOTE_SEQ) begin
              if (limit != 0) begin
                seq_on   = 1'b1;
                r.status = ST_SEQ_START;
              end
            end else begin
              s  = 0;
              go = 1'b1;
              if (key != NOTE_PREVIEW) begin
                s = key_to_slice(key);
                if (s < 0 || s >= limit) go = 1'b0;
                else if (oneshot_bits[s]) begin
                  // one-shot retrigger silences its slice first
                  for (int i = 0; i < VOICES; i++)
                    if (voice_on[i] && voice_slice[i] == s[5:0]) voice_on[i] = 1'b0;
                end
              end
              if (go) begin
                v = -1;
                for (int i = 0; i < VOICES; i++)
                  if (!voice_on[i] && v < 0) v = i;
                if (v < 0) begin
                  v         = int'(steal_ptr);
                  steal_ptr = steal_ptr + 4'd1;
                end
                r.stolen       = voice_on[v];
                voice_on[v]    = 1'b1;
                voice_key[v]   = key;
                voice_slice[v] = s[5:0];
                r.voice        = v[3:0];
                r.slice        = s[5:0];
                r.vel          = vel;
                if (key == NOTE_PREVIEW) r.status = ST_PREVIEW;
                else r.status = ST_SLICE;
              end
            end
          end
        end
        OP_NOTE_OFF: begin
          if (key == NOTE_SEQ) begin
            seq_on   = 1'b0;
            r.status = ST_SEQ_STOP;
          end else begin
            for (int i = 0; i < VOICES; i++)
              if (voice_on[i] && voice_key[i] == key && !oneshot_bits[voice_slice[i]])
                voice_on[i] = 1'b0;
            r.status = ST_RELEASED;
          end
        end
        OP_ALL_OFF: begin
          voice_on = '0;
          r.status = ST_ALL_OFF;
        end
        default: begin
          if (fin < VOICES) begin
            voice_on[fin] = 1'b0;
            r.status      = ST_FINISHED;
          end
        end
      endcase
      r.released = was_on & ~voice_on;
      r.active   = voice_on;
      r.seq      = seq_on;
      due_results.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [2:0] status, logic [55:0] data);
      voice_result_t want;
      if (due_results.size() == 0) begin
        report("unexpected result item, status", 64'(status), 64'd0);
        return;
      end
      want = due_results.pop_front();
      if (status      !== want.status)   report("status", status, want.status);
      if (data[3:0]   !== want.voice)    report("voice_index", data[3:0], want.voice);
      if (data[9:4]   !== want.slice)    report("slice_num", data[9:4], want.slice);
      if (data[16:10] !== want.vel)      report("velocity_out", data[16:10], want.vel);
      if (data[17]    !== want.stolen)   report("stolen", data[17], want.stolen);
      if (data[33:18] !== want.released) report("released_mask", data[33:18], want.released);
      if (data[49:34] !== want.active)   report("active_mask", data[49:34], want.active);
      if (data[50]    !== want.seq)      report("seq_running", data[50], want.seq);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  voice_scoreboard sb;
  logic            no_idle;        // phase with back-to-back items on both sides
  logic [6:0]      played_keys[$]; // recent note-on keys, reused for note-offs

  sampler_voice_allocator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous bound, well above the slowest legal run
  initial begin
    #6_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid is only lowered when a gap follows, so back-to-back items keep it
  // high without a second assignment in the same step.
  task automatic send_event(op_e op, logic [6:0] key, logic [6:0] vel, logic [3:0] fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, fin, vel, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(op, key, vel, fin);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, value);
  endtask

  task automatic configure(logic present, logic [6:0] count, logic [63:0] mask);
    write_reg(CFG_SAMPLE_PRESENT, {63'b0, present});
    write_reg(CFG_SLICE_COUNT, {57'b0, count});
    write_reg(CFG_ONE_SHOT_MASK, mask);
    cfg_valid_i <= 1'b0;
  endtask

  // every item yields a result, so an empty queue means the block is idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // random events biased toward playable keys and recently played notes
  task automatic random_events(int wanted);
    int         sent;
    int         r;
    int         span;
    int         limit;
    logic [6:0] key;
    op_e        op;
    sent   = 0;
    limit  = (int'(sb.slice_total) > 64) ? 64 : int'(sb.slice_total);
    span   = (limit == 0) ? 11 : ((limit + 6) / 7) * 12;
    if (span > 91) span = 91;
    while (sent < wanted) begin
      r   = $urandom_range(0, 99);
      key = 7'($urandom_range(0, 127));
      if (r < 62) begin
        op = OP_NOTE_ON;
        r  = $urandom_range(0, 99);
        if (r < 55) key = 7'(int'(NOTE_BASE) + $urandom_range(0, span));
        else if (r < 65) key = NOTE_PREVIEW;
        else if (r < 70) key = NOTE_SEQ;
      end else if (r < 85) begin
        op = OP_NOTE_OFF;
        r  = $urandom_range(0, 99);
        if (r < 60 && played_keys.size() != 0)
          key = played_keys[$urandom_range(0, played_keys.size() - 1)];
        else if (r < 65) key = NOTE_SEQ;
      end else if (r < 88) begin
        op = OP_ALL_OFF;
      end else begin
        op = OP_FINISHED;
      end
      send_event(op, key, 7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
      if (op == OP_NOTE_ON) begin
        played_keys.push_back(key);
        if (played_keys.size() > 16) void'(played_keys.pop_front());
      end
      sent++;
    end
  endtask

  // result side: checks every accepted item, stalls at random
  initial begin
    int   hold;
    int   r;
    logic ready_now;
    m_axis_tready = 1'b0;
    hold          = 0;
    ready_now     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (hold == 0) begin
          r         = $urandom_range(0, 99);
          ready_now = (r < 70);
          hold      = (r > 95) ? $urandom_range(20, 60) : $urandom_range(0, 4);
        end else begin
          hold--;
        end
        m_axis_tready <= ready_now;
      end
    end
  end

  initial begin
    sb            = new();
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NOTE_ON;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_SAMPLE_PRESENT;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no sample loaded: note-on ignored, note-off and finished still act
    send_event(OP_NOTE_ON, 7'd60, 7'd100, 4'd0);
    send_event(OP_NOTE_OFF, NOTE_SEQ, 7'd0, 4'd0);
    send_event(OP_FINISHED, 7'd0, 7'd0, 4'd15);
    wait_idle();

    // sample with no slices: sequencer start refused, preview still plays
    configure(1'b1, 7'd0, 64'd0);
    send_event(OP_NOTE_ON, NOTE_SEQ, 7'd1, 4'd0);
    send_event(OP_NOTE_ON, NOTE_PREVIEW, 7'd127, 4'd0);
    send_event(OP_NOTE_ON, NOTE_BASE, 7'd5, 4'd0);
    wait_idle();

    // full slice range, slices 0 and 2 one-shot
    configure(1'b1, 7'd64, 64'h5);
    send_event(OP_NOTE_ON, NOTE_SEQ, 7'd3, 4'd0);
    // retrigger on slice 0 silences the preview voice and reuses it
    send_event(OP_NOTE_ON, NOTE_BASE, 7'd0, 4'd0);
    send_event(OP_NOTE_ON, NOTE_BASE, 7'd127, 4'd0);
    send_event(OP_NOTE_ON, 7'd40, 7'd64, 4'd0);
    send_event(OP_NOTE_ON, 7'd38, 7'd33, 4'd0);
    send_event(OP_NOTE_ON, 7'd0, 7'd9, 4'd0);      // below the base note
    send_event(OP_NOTE_ON, 7'd61, 7'd9, 4'd0);     // black key
    send_event(OP_NOTE_ON, 7'd127, 7'd127, 4'd0);  // top key, slice 53
    send_event(OP_NOTE_OFF, NOTE_BASE, 7'd0, 4'd0); // one-shot voice spared
    send_event(OP_NOTE_OFF, 7'd127, 7'd0, 4'd0);
    send_event(OP_NOTE_OFF, 7'd5, 7'd0, 4'd0);     // nothing to release
    send_event(OP_FINISHED, 7'd0, 7'd0, 4'd0);
    send_event(OP_ALL_OFF, 7'd0, 7'd0, 4'd0);      // sequencer flag kept
    send_event(OP_NOTE_OFF, NOTE_SEQ, 7'd0, 4'd0);
    wait_idle();

    // three slices, all one-shot: slice 4 is out of range
    configure(1'b1, 7'd3, '1);
    send_event(OP_NOTE_ON, 7'd43, 7'd20, 4'd0);
    send_event(OP_NOTE_ON, NOTE_BASE, 7'd21, 4'd0);
    send_event(OP_NOTE_ON, NOTE_BASE, 7'd22, 4'd0);
    wait_idle();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(1'b1, 7'd64, 64'd0);
        1: configure(1'b1, 7'd7, '1);
        2: configure(1'b0, 7'($urandom_range(0, 64)), {$urandom, $urandom});
        3: configure(1'b1, 7'd127, {$urandom, $urandom});
        4: configure(1'b1, 7'd1, 64'd1);
        5: configure(1'b1, 7'($urandom_range(0, 64)),
                     {$urandom, $urandom} & {$urandom, $urandom});
        6: configure(1'b1, 7'($urandom_range(8, 64)), {$urandom, $urandom});
        default: configure(1'b1, 7'd0, 64'd0);
      endcase
      no_idle = (ph == 3 || ph == 6);
      random_events(110);
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sampler_voice_allocator_top.f =====
rtl/core/sva_pkg.sv
rtl/core/sva_note_map.sv
rtl/core/sva_voice_engine.sv
rtl/core/sampler_voice_allocator_top.sv
test/tb.sv
